### rtl/core/gn2d_pkg.sv
// ----------------------------------------------------------------------------
// gn2d_pkg: shared constants, types and helpers of the 2d gradient noise unit
// Field widths, command and status codes, register indexes and the fixed-point
// formats used by the dot, fade and blend datapath.
// ----------------------------------------------------------------------------
package gn2d_pkg;

  // defaults of the top level parameters
  localparam int MAX_GRID_DEFAULT   = 63;
  localparam int COORD_FRAC_DEFAULT = 10;

  // request / response field widths
  localparam int GRID_W     = 6;
  localparam int GRAD_W     = 16;
  localparam int COORD_W    = 16;
  localparam int NOISE_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;

  // stored gradient component, Q1.14 in 15 bits
  localparam int COMP_W     = 15;

  // datapath formats
  localparam int T_W        = 16;            // fraction, Q0.16
  localparam int FADE_W     = 17;            // fade weight, Q0.16 plus headroom
  localparam int Q_W        = 21;            // fade polynomial inner term
  localparam int OFS_W      = 17;            // corner offset, signed Q1.16
  localparam int PROD_W     = 32;            // gradient times offset
  localparam int DOT_W      = 33;            // dot product, Q.30
  localparam int ROW_W      = DOT_W + 1;     // result of a blend along x
  localparam int OUT_W      = ROW_W + 1;     // result of the blend along y
  localparam int SPLIT_W    = 17;            // low slice of a blend difference
  localparam int ADDR_PW    = 2 * GRID_W + 1;

  localparam int FADE_ONE   = 1 << T_W;
  localparam int ROUND_HALF = 1 << (T_W - 1);
  localparam int NOISE_MAX  = (1 << (NOISE_W - 1)) - 1;
  localparam int NOISE_MIN  = -(1 << (NOISE_W - 1));
  localparam int GRID_TOP   = (1 << GRID_W) - 1;

  // output queue and fixed pipeline timing
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int TAG_LAT    = 11;            // last table access to queue push
  localparam int FY_DLY     = 4;             // y weight delay up to the y blend

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  // response status codes
  localparam status_t ST_NOISE    = 2'd0;
  localparam status_t ST_WR_DONE  = 2'd1;
  localparam status_t ST_WR_RANGE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  // corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef struct packed {
    logic signed [COMP_W-1:0] gx;
    logic signed [COMP_W-1:0] gy;
  } grad_t;

  // clip a Q2.14 request component into the stored 15 bit range
  function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [GRAD_W-1:0] v);
    logic signed [COMP_W-1:0] r;
    begin
      if (v[GRAD_W-1] == v[GRAD_W-2]) begin
        r = v[COMP_W-1:0];
      end else if (v[GRAD_W-1] == 1'b0) begin
        r = {1'b0, {(COMP_W-1){1'b1}}};
      end else begin
        r = {1'b1, {(COMP_W-1){1'b0}}};
      end
      return r;
    end
  endfunction

endpackage

### rtl/core/gn2d_if.sv
// ----------------------------------------------------------------------------
// gn2d_if: channels of the 2d gradient noise unit
// Request, response and register write channels, each with valid / ready.
// ----------------------------------------------------------------------------
interface gn2d_req_if import gn2d_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [GRID_W-1:0]        grid_x;
  logic [GRID_W-1:0]        grid_y;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [COORD_W-1:0]       coord_x;
  logic [COORD_W-1:0]       coord_y;

  modport source (
    output valid, command, grid_x, grid_y, grad_x, grad_y, coord_x, coord_y,
    input  ready
  );
  modport sink (
    input  valid, command, grid_x, grid_y, grad_x, grad_y, coord_x, coord_y,
    output ready
  );
endinterface

interface gn2d_rsp_if import gn2d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;
  status_t                   status;

  modport source (output valid, noise_value, status, input ready);
  modport sink   (input valid, noise_value, status, output ready);
endinterface

interface gn2d_cfg_if import gn2d_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GRID_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/gn2d_fade.sv
// ----------------------------------------------------------------------------
// gn2d_fade: quintic fade weight 6t^5 - 15t^4 + 10t^3
// Three register stages; a fraction presented in one cycle gives its weight
// at the output of the third stage. Runs every cycle, no stall.
// ----------------------------------------------------------------------------
module gn2d_fade import gn2d_pkg::*; (
  input  logic              clk,
  input  logic [T_W-1:0]    t,
  output logic [FADE_W-1:0] f
);

  logic [T_W-1:0]       t1;
  logic [T_W-1:0]       t2;
  logic [T_W-1:0]       t3;
  logic [Q_W-1:0]       q;
  logic [2*T_W-1:0]     sq;
  logic [2*T_W-1:0]     cu;
  logic [Q_W-1:0]       q_next;
  logic [T_W+Q_W-1:0]   fp;

  // products of each stage
  always_comb begin
    sq     = (2*T_W)'(t) * (2*T_W)'(t);
    cu     = (2*T_W)'(t2) * (2*T_W)'(t1);
    q_next = Q_W'(t2) * Q_W'(6) + Q_W'(10 * FADE_ONE) - Q_W'(t1) * Q_W'(15);
    fp     = (T_W+Q_W)'(t3) * (T_W+Q_W)'(q);
  end

  // t^2, then t^3 with the inner term, then the weight
  always_ff @(posedge clk) begin
    t1 <= t;
    t2 <= sq[2*T_W-1:T_W];
    t3 <= cu[2*T_W-1:T_W];
    q  <= q_next;
    f  <= fp[T_W+FADE_W-1:T_W];
  end

endmodule

### rtl/core/gn2d_blend.sv
// ----------------------------------------------------------------------------
// gn2d_blend: weighted blend y = a + floor((b - a) * f / 2^16)
// Four register stages: difference, split partial products, recombine and
// shift, add. The wide product is cut in two narrow multiplies.
// ----------------------------------------------------------------------------
module gn2d_blend import gn2d_pkg::*; #(
  parameter int W = DOT_W
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic [FADE_W-1:0]   f,
  output logic signed [W:0]   y
);

  localparam int HI_W  = W + 1 - SPLIT_W;
  localparam int PH_W  = HI_W + FADE_W + 1;
  localparam int PL_W  = SPLIT_W + FADE_W;
  localparam int CB_W  = PH_W + SPLIT_W;
  localparam int SH_W  = CB_W - T_W;

  logic signed [W:0]      diff;
  logic signed [HI_W-1:0] d_hi;
  logic [SPLIT_W-1:0]     d_lo;
  logic [FADE_W-1:0]      f1;
  logic signed [W-1:0]    a1;
  logic signed [W-1:0]    a2;
  logic signed [W-1:0]    a3;
  logic signed [PH_W-1:0] ph;
  logic [PL_W-1:0]        pl;
  logic signed [CB_W-1:0] comb;
  logic signed [SH_W-1:0] sh;
  logic signed [SH_W-1:0] sum;

  always_comb begin
    diff = (W+1)'(b) - (W+1)'(a);
    comb = (CB_W'(ph) <<< SPLIT_W) + CB_W'(signed'({1'b0, pl}));
    sum  = SH_W'(a3) + sh;
  end

  // difference split into a signed high and an unsigned low slice
  always_ff @(posedge clk) begin
    d_hi <= diff[W:SPLIT_W];
    d_lo <= diff[SPLIT_W-1:0];
    f1   <= f;
    a1   <= a;
  end

  // partial products
  always_ff @(posedge clk) begin
    ph <= PH_W'(d_hi) * PH_W'(signed'({1'b0, f1}));
    pl <= PL_W'(d_lo) * PL_W'(f1);
    a2 <= a1;
  end

  // recombine, floor division by 2^16
  always_ff @(posedge clk) begin
    sh <= comb[CB_W-1:T_W];
    a3 <= a2;
  end

  // final add
  always_ff @(posedge clk) begin
    y <= sum[W:0];
  end

endmodule

### rtl/core/gradient_noise_2d_unit.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_unit: 2d gradient noise over a table of lattice gradients
//
// Channels: req carries one request, a gradient write (command 0) or a noise
// query (command 1); rsp returns one response per request, in request order;
// cfg writes grid_width (index 0) and grid_height (index 1). The user must
// write them only while idle; the block itself does not enforce this.
// A write makes one access to the single-port gradient table, a query reads
// its four corners from it, one read per cycle; the next request can be
// accepted in the cycle of the last table access of the one before.
// Results wait in a 16-entry response queue; requests keep being accepted
// while the receiver stalls, until 16 requests are outstanding.
// Reset: lattice size goes to its largest value, pipeline and queue empty.
// The table is not cleared: each entry is undefined until written, and a
// gradient must be written before a query reads it. A write goes to the table
// before any later query reads, so no forwarding is needed.
// ----------------------------------------------------------------------------
module gradient_noise_2d_unit import gn2d_pkg::*; #(
  parameter int MAX_GRID        = MAX_GRID_DEFAULT,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  gn2d_cfg_if.sink    cfg,
  gn2d_req_if.sink    req,
  gn2d_rsp_if.source  rsp
);

  localparam int DEPTH = (MAX_GRID + 1) * (MAX_GRID + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = COORD_W + 1 - COORD_FRAC_BITS;
  localparam int CW    = (XW > GRID_W) ? XW : GRID_W;
  localparam int SH    = T_W - COORD_FRAC_BITS;
  localparam logic [COORD_W-1:0] FMASK =
    COORD_W'((64'd1 << COORD_FRAC_BITS) - 64'd1);
  localparam logic [GRID_W-1:0] GRID_RST =
    GRID_W'((MAX_GRID < GRID_TOP) ? MAX_GRID : GRID_TOP);

  // lattice size registers
  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_height;
  logic [GRID_W-1:0] cfg_clamped;

  // issue stage
  logic              iss_valid;
  logic              iss_cmd;
  logic [1:0]        iss_cnt;
  logic [XW-1:0]     iss_x0;
  logic [XW-1:0]     iss_y0;
  logic [T_W-1:0]    iss_tx;
  logic [T_W-1:0]    iss_ty;
  logic [GRID_W-1:0] iss_wx;
  logic [GRID_W-1:0] iss_wy;
  grad_t             iss_grad;
  logic              iss_done;
  logic              req_fire;

  // corner and write addressing
  logic [XW-1:0]      cx;
  logic [XW-1:0]      cy;
  logic [CW-1:0]      cx_ext;
  logic [CW-1:0]      cy_ext;
  logic               corner_out;
  logic               wr_out;
  logic [ADDR_PW-1:0] row_len;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic               mem_re;
  logic signed [OFS_W-1:0] dx;
  logic signed [OFS_W-1:0] dy;

  // gradient table
  grad_t mem [DEPTH];
  grad_t rd_data;

  // dot product stages
  logic                     m_valid;
  logic                     m_zero;
  logic [1:0]               m_corner;
  logic signed [OFS_W-1:0]  m_dx;
  logic signed [OFS_W-1:0]  m_dy;
  grad_t                    gsel;
  logic                     p_valid;
  logic [1:0]               p_corner;
  logic signed [PROD_W-1:0] p_px;
  logic signed [PROD_W-1:0] p_py;
  logic signed [DOT_W-1:0]  dot [4];

  // fade and blend
  logic [FADE_W-1:0]        fade_x;
  logic [FADE_W-1:0]        fade_y;
  logic [FADE_W-1:0]        fx_hold;
  logic [FADE_W-1:0]        fy_hold;
  logic [FADE_W-1:0]        fyd [FY_DLY];
  logic signed [ROW_W-1:0]  row0;
  logic signed [ROW_W-1:0]  row1;
  logic signed [OUT_W-1:0]  mix;
  logic signed [OUT_W-1:0]  rsum;
  logic signed [OUT_W-1:0]  rq;
  logic signed [NOISE_W-1:0] noise_sat;

  // response tags and queue
  logic                      tag_valid  [TAG_LAT];
  status_t                   tag_status [TAG_LAT];
  logic                      push;
  logic                      pop;
  logic [NOISE_W-1:0]        push_noise;
  logic [NOISE_W-1:0]        fifo_noise  [FIFO_DEPTH];
  status_t                   fifo_status [FIFO_DEPTH];
  logic [FIFO_AW-1:0]        wptr;
  logic [FIFO_AW-1:0]        rptr;
  logic [FIFO_AW:0]          fcnt;
  logic [FIFO_AW:0]          inflight;

  // ---------------------------------------------------------------------------
  // register writes
  // ---------------------------------------------------------------------------
  assign cfg.ready   = 1'b1;
  assign cfg_clamped = (32'(cfg.data) > 32'(MAX_GRID)) ? GRID_W'(MAX_GRID) : cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RST;
      grid_height <= GRID_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GRID_WIDTH:  grid_width  <= cfg_clamped;
        REG_GRID_HEIGHT: grid_height <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request acceptance and issue sequencing
  // ---------------------------------------------------------------------------
  assign iss_done  = iss_valid && (iss_cmd == CMD_WRITE || iss_cnt == CORNER_LAST);
  assign req.ready = (!iss_valid || iss_done) &&
                     (inflight < (FIFO_AW+1)'(FIFO_DEPTH));
  assign req_fire  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
      iss_cnt   <= 2'd0;
    end else if (req_fire) begin
      iss_valid <= 1'b1;
      iss_cnt   <= 2'd0;
    end else if (iss_done) begin
      iss_valid <= 1'b0;
    end else if (iss_valid) begin
      iss_cnt   <= iss_cnt + 2'd1;
    end
  end

  // request payload split into lattice cell and fraction
  always_ff @(posedge clk) begin
    if (req_fire) begin
      iss_cmd  <= req.command;
      iss_x0   <= XW'(req.coord_x >> COORD_FRAC_BITS);
      iss_y0   <= XW'(req.coord_y >> COORD_FRAC_BITS);
      iss_tx   <= T_W'((req.coord_x & FMASK) << SH);
      iss_ty   <= T_W'((req.coord_y & FMASK) << SH);
      iss_wx   <= req.grid_x;
      iss_wy   <= req.grid_y;
      iss_grad <= '{gx: sat_comp(req.grad_x), gy: sat_comp(req.grad_y)};
    end
  end

  // corner position, lattice check and table address
  always_comb begin
    cx         = iss_x0 + XW'(iss_cnt[0]);
    cy         = iss_y0 + XW'(iss_cnt[1]);
    cx_ext     = CW'(cx);
    cy_ext     = CW'(cy);
    corner_out = (cx_ext > CW'(grid_width)) || (cy_ext > CW'(grid_height));
    wr_out     = (iss_wx > grid_width) || (iss_wy > grid_height);
    row_len    = ADDR_PW'(grid_width) + ADDR_PW'(1);
    rd_addr    = AW'(ADDR_PW'(cy_ext[GRID_W-1:0]) * row_len + ADDR_PW'(cx_ext[GRID_W-1:0]));
    wr_addr    = AW'(ADDR_PW'(iss_wy) * row_len + ADDR_PW'(iss_wx));
    mem_we     = iss_valid && iss_cmd == CMD_WRITE && !wr_out;
    mem_re     = iss_valid && iss_cmd == CMD_QUERY && !corner_out;
    mem_addr   = (iss_cmd == CMD_WRITE) ? wr_addr : rd_addr;
    dx         = iss_cnt[0] ? OFS_W'(iss_tx) - OFS_W'(FADE_ONE) : OFS_W'(iss_tx);
    dy         = iss_cnt[1] ? OFS_W'(iss_ty) - OFS_W'(FADE_ONE) : OFS_W'(iss_ty);
  end

  // ---------------------------------------------------------------------------
  // gradient table, single port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= iss_grad;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // dot products, one corner per cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      m_valid <= iss_valid && iss_cmd == CMD_QUERY;
      p_valid <= m_valid;
    end
  end

  // corners off the lattice use a zero gradient
  assign gsel = m_zero ? '0 : rd_data;

  always_ff @(posedge clk) begin
    m_zero   <= corner_out;
    m_corner <= iss_cnt;
    m_dx     <= dx;
    m_dy     <= dy;
    p_corner <= m_corner;
    p_px     <= PROD_W'(gsel.gx) * PROD_W'(m_dx);
    p_py     <= PROD_W'(gsel.gy) * PROD_W'(m_dy);
    if (p_valid) begin
      dot[p_corner] <= DOT_W'(p_px) + DOT_W'(p_py);
    end
  end

  // ---------------------------------------------------------------------------
  // fade weights, latched at the last corner read of a query
  // ---------------------------------------------------------------------------
  gn2d_fade u_fade_x (.clk(clk), .t(iss_tx), .f(fade_x));
  gn2d_fade u_fade_y (.clk(clk), .t(iss_ty), .f(fade_y));

  always_ff @(posedge clk) begin
    if (iss_done && iss_cmd == CMD_QUERY) begin
      fx_hold <= fade_x;
      fy_hold <= fade_y;
    end
    fyd[0] <= fy_hold;
    for (int i = 1; i < FY_DLY; i++) begin
      fyd[i] <= fyd[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // blend along x for both rows, then along y
  // ---------------------------------------------------------------------------
  gn2d_blend #(.W(DOT_W)) u_blend_r0 (
    .clk(clk), .a(dot[0]), .b(dot[1]), .f(fx_hold), .y(row0)
  );
  gn2d_blend #(.W(DOT_W)) u_blend_r1 (
    .clk(clk), .a(dot[2]), .b(dot[3]), .f(fx_hold), .y(row1)
  );
  gn2d_blend #(.W(ROW_W)) u_blend_col (
    .clk(clk), .a(row0), .b(row1), .f(fyd[FY_DLY-1]), .y(mix)
  );

  // round half up to Q2.14 and saturate
  always_comb begin
    rsum = mix + OUT_W'(ROUND_HALF);
    rq   = rsum >>> T_W;
    if (rq > OUT_W'(NOISE_MAX)) begin
      noise_sat = NOISE_W'(NOISE_MAX);
    end else if (rq < OUT_W'(NOISE_MIN)) begin
      noise_sat = NOISE_W'(NOISE_MIN);
    end else begin
      noise_sat = rq[NOISE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // response tags: fixed delay from the last table access to the queue
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAG_LAT; i++) begin
        tag_valid[i] <= 1'b0;
      end
    end else begin
      tag_valid[0] <= iss_done;
      for (int i = 1; i < TAG_LAT; i++) begin
        tag_valid[i] <= tag_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_cmd == CMD_QUERY) begin
      tag_status[0] <= ST_NOISE;
    end else if (wr_out) begin
      tag_status[0] <= ST_WR_RANGE;
    end else begin
      tag_status[0] <= ST_WR_DONE;
    end
    for (int i = 1; i < TAG_LAT; i++) begin
      tag_status[i] <= tag_status[i-1];
    end
  end

  assign push       = tag_valid[TAG_LAT-1];
  assign push_noise = (tag_status[TAG_LAT-1] == ST_NOISE) ? noise_sat : '0;

  // ---------------------------------------------------------------------------
  // response queue and outstanding request count
  // ---------------------------------------------------------------------------
  assign pop             = rsp.valid && rsp.ready;
  assign rsp.valid       = fcnt != '0;
  assign rsp.noise_value = fifo_noise[rptr];
  assign rsp.status      = fifo_status[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_noise[wptr]  <= push_noise;
      fifo_status[wptr] <= tag_status[TAG_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= '0;
      rptr     <= '0;
      fcnt     <= '0;
      inflight <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + FIFO_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      fcnt     <= fcnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
      inflight <= inflight + (FIFO_AW+1)'(req_fire) - (FIFO_AW+1)'(pop);
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // outstanding requests stay within the queue depth
  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("outstanding request count above queue depth");

  // the queue never takes a result while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> fcnt < (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("response queue overflow");

  // every queued response belongs to an accepted request
  a_queue_le_inflight: assert property (@(posedge clk) disable iff (rst)
    fcnt <= inflight)
    else $error("more queued responses than outstanding requests");

  // a query walks its corners in consecutive cycles
  a_corner_walk: assert property (@(posedge clk) disable iff (rst)
    (iss_valid && iss_cmd == CMD_QUERY && !iss_done) |=>
      (iss_valid && iss_cnt == $past(iss_cnt) + 2'd1))
    else $error("query corner sequence broken");

  // a noise result lines up with the last corner read of its query
  a_noise_timing: assert property (@(posedge clk) disable iff (rst)
    (push && tag_status[TAG_LAT-1] == ST_NOISE) |->
      $past(iss_done && iss_cmd == CMD_QUERY, TAG_LAT))
    else $error("noise result out of step with its query");

endmodule

### tb/sv/gn2d_noise_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gn2d_noise_checker: response checker of the 2d gradient noise unit
// Follows register writes and accepted requests, keeps its own copy of the
// gradient table and lattice size, predicts the response of every request and
// compares each accepted response, field by field, in request order.
// ----------------------------------------------------------------------------
module gn2d_noise_checker import gn2d_pkg::*; (
  input  logic clk,
  input  logic rst,
  gn2d_cfg_if  cfg,
  gn2d_req_if  req,
  gn2d_rsp_if  rsp,
  output int   mismatch_count,
  output int   owed_count
);

  localparam int FRAC        = COORD_FRAC_DEFAULT;
  localparam int LATTICE_N   = MAX_GRID_DEFAULT + 1;
  localparam int TABLE_DEPTH = LATTICE_N * LATTICE_N;
  localparam int COMP_MAX    = (1 << (COMP_W - 1)) - 1;
  localparam int COMP_MIN    = -(1 << (COMP_W - 1));

  typedef struct {
    logic signed [NOISE_W-1:0] noise;
    status_t                   status;
  } noise_rsp_t;

  grad_t      grad_store [TABLE_DEPTH];
  int         lat_w;
  int         lat_h;
  noise_rsp_t owed_rsp [$];
  int         errors;

  // stored component range is one bit narrower than the request field
  function automatic logic signed [COMP_W-1:0] clip_comp(logic signed [GRAD_W-1:0] v);
    if (v > COMP_MAX) return COMP_MAX[COMP_W-1:0];
    if (v < COMP_MIN) return COMP_MIN[COMP_W-1:0];
    return v[COMP_W-1:0];
  endfunction

  function automatic int clip_grid(logic [GRID_W-1:0] v);
    return (int'(v) > MAX_GRID_DEFAULT) ? MAX_GRID_DEFAULT : int'(v);
  endfunction

  // dot product of one corner gradient with its offset, zero off the lattice
  function automatic longint corner_dot(int x, int y, longint dx, longint dy);
    grad_t g;
    g = '0;
    if (x <= lat_w && y <= lat_h) g = grad_store[y * (lat_w + 1) + x];
    return longint'(signed'(g.gx)) * dx + longint'(signed'(g.gy)) * dy;
  endfunction

  // quintic fade 6t^5 - 15t^4 + 10t^3 in Q0.16
  function automatic longint smooth_weight(longint t);
    longint t2, t3, q;
    t2 = (t * t) >> T_W;
    t3 = (t2 * t) >> T_W;
    q  = 6 * t2 + 10 * FADE_ONE - 15 * t;
    return (t3 * q) >> T_W;
  endfunction

  // a + (b - a) * w, floored
  function automatic longint mix(longint a, longint b, longint w);
    return a + (((b - a) * w) >>> T_W);
  endfunction

  function automatic logic signed [NOISE_W-1:0] noise_at(logic [COORD_W-1:0] cx,
                                                          logic [COORD_W-1:0] cy);
    int     x0, y0;
    longint tx, ty, wx, wy, row0, row1, r;
    x0   = int'(cx >> FRAC);
    y0   = int'(cy >> FRAC);
    tx   = longint'(cx[FRAC-1:0]) << (T_W - FRAC);
    ty   = longint'(cy[FRAC-1:0]) << (T_W - FRAC);
    wx   = smooth_weight(tx);
    wy   = smooth_weight(ty);
    row0 = mix(corner_dot(x0, y0, tx, ty),
               corner_dot(x0 + 1, y0, tx - FADE_ONE, ty), wx);
    row1 = mix(corner_dot(x0, y0 + 1, tx, ty - FADE_ONE),
               corner_dot(x0 + 1, y0 + 1, tx - FADE_ONE, ty - FADE_ONE), wx);
    r    = (mix(row0, row1, wy) + ROUND_HALF) >>> T_W;
    if (r > NOISE_MAX) r = NOISE_MAX;
    if (r < NOISE_MIN) r = NOISE_MIN;
    return r[NOISE_W-1:0];
  endfunction

  always @(posedge clk) begin
    noise_rsp_t next_rsp;
    noise_rsp_t head;
    int         slot;
    if (rst) begin
      lat_w  = MAX_GRID_DEFAULT;
      lat_h  = MAX_GRID_DEFAULT;
      errors = 0;
      owed_rsp.delete();
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_GRID_WIDTH) lat_w = clip_grid(cfg.data);
        else lat_h = clip_grid(cfg.data);
      end

      // response against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (owed_rsp.size() == 0) begin
          $error("unexpected response: noise_value %0d status %0d",
                 rsp.noise_value, rsp.status);
          errors++;
        end else begin
          head = owed_rsp.pop_front();
          if (rsp.noise_value !== head.noise) begin
            $error("noise_value: expected %0d, actual %0d", head.noise, rsp.noise_value);
            errors++;
          end
          if (rsp.status !== head.status) begin
            $error("status: expected %0d, actual %0d", head.status, rsp.status);
            errors++;
          end
        end
      end

      // accepted request: update the table or predict the noise
      if (req.valid && req.ready) begin
        next_rsp.noise = '0;
        if (req.command == CMD_WRITE) begin
          if (int'(req.grid_x) > lat_w || int'(req.grid_y) > lat_h) begin
            next_rsp.status = ST_WR_RANGE;
          end else begin
            slot = int'(req.grid_y) * (lat_w + 1) + int'(req.grid_x);
            grad_store[slot].gx = clip_comp(req.grad_x);
            grad_store[slot].gy = clip_comp(req.grad_y);
            next_rsp.status = ST_WR_DONE;
          end
        end else begin
          next_rsp.noise  = noise_at(req.coord_x, req.coord_y);
          next_rsp.status = ST_NOISE;
        end
        owed_rsp.push_back(next_rsp);
      end
    end
    mismatch_count <= errors;
    owed_count     <= owed_rsp.size();
  end

endmodule

### tb/sv/gradient_noise_2d_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_unit_test: testbench of the 2d gradient noise unit
// Directed gradient writes and noise queries at lattice edges, then random
// request mixes over several lattice sizes with random gaps and stalls on
// both channels. Every corner a query reads is written first. A separate
// checker predicts and compares all responses.
// ----------------------------------------------------------------------------
module gradient_noise_2d_unit_test;
  import gn2d_pkg::*;

  localparam int FRAC           = COORD_FRAC_DEFAULT;
  localparam int FRAC_TOP       = (1 << FRAC) - 1;
  localparam int LATTICE_N      = MAX_GRID_DEFAULT + 1;
  localparam int TABLE_DEPTH    = LATTICE_N * LATTICE_N;
  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int STALL_PCT      = 30;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst;
  logic steady = 1'b0;
  int   mismatch_count;
  int   owed_count;
  int   sent_total = 0;
  int   quiet_cycles = 0;
  int   lat_w;
  int   lat_h;
  bit   written [TABLE_DEPTH];

  gn2d_cfg_if cfg ();
  gn2d_req_if req ();
  gn2d_rsp_if rsp ();

  gradient_noise_2d_unit u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  gn2d_noise_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .req            (req),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .owed_count     (owed_count)
  );

  always #HALF_PERIOD clk = ~clk;

  // gradient values: mostly in range, some edges, a few full 16 bit patterns
  function automatic logic signed [GRAD_W-1:0] pick_grad();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 5) begin
      v = $urandom_range(16'hFFFF);
    end else if (r < 15) begin
      case ($urandom_range(3))
        0:       v = 16384;
        1:       v = -16384;
        2:       v = 16383;
        default: v = 0;
      endcase
    end else begin
      v = int'($urandom_range(32768)) - 16384;
    end
    return v[GRAD_W-1:0];
  endfunction

  function automatic logic [FRAC-1:0] pick_frac();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return FRAC_TOP[FRAC-1:0];
    return FRAC'($urandom);
  endfunction

  // lattice cell near the lattice, sometimes anywhere
  function automatic int pick_cell(int lim);
    if ($urandom_range(99) < 15) return $urandom_range(GRID_TOP);
    return $urandom_range((lim < GRID_TOP) ? lim + 1 : GRID_TOP);
  endfunction

  // one request, with a random gap in front of it
  task automatic send_req(logic command, int gx, int gy,
                          logic signed [GRAD_W-1:0] ax, logic signed [GRAD_W-1:0] ay,
                          logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    if (!steady && $urandom_range(99) < STALL_PCT) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < STALL_PCT);
    end
    req.valid   <= 1'b1;
    req.command <= command;
    req.grid_x  <= gx[GRID_W-1:0];
    req.grid_y  <= gy[GRID_W-1:0];
    req.grad_x  <= ax;
    req.grad_y  <= ay;
    req.coord_x <= cx;
    req.coord_y <= cy;
    do @(posedge clk); while (!req.ready);
    sent_total++;
    if (command == CMD_WRITE && gx <= lat_w && gy <= lat_h)
      written[gy * (lat_w + 1) + gx] = 1'b1;
  endtask

  task automatic grad_write(int x, int y);
    send_req(CMD_WRITE, x, y, pick_grad(), pick_grad(), COORD_W'($urandom),
             COORD_W'($urandom));
  endtask

  // query, after writing any lattice corner not yet holding a gradient
  task automatic noise_query(int x0, int y0, logic [FRAC-1:0] fx, logic [FRAC-1:0] fy);
    int x;
    int y;
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        x = x0 + dx;
        y = y0 + dy;
        if (x <= lat_w && y <= lat_h && !written[y * (lat_w + 1) + x]) grad_write(x, y);
      end
    end
    send_req(CMD_QUERY, $urandom_range(GRID_TOP), $urandom_range(GRID_TOP),
             pick_grad(), pick_grad(), {x0[GRID_W-1:0], fx}, {y0[GRID_W-1:0], fy});
  endtask

  // hold requests until every response is back
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
  endtask

  task automatic set_lattice(int w, int h);
    cfg.valid <= 1'b1;
    cfg.index <= REG_GRID_WIDTH;
    cfg.data  <= w[GRID_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.index <= REG_GRID_HEIGHT;
    cfg.data  <= h[GRID_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    lat_w = w;
    lat_h = h;
  endtask

  // random mix of queries, in-lattice writes and writes anywhere
  task automatic mix_phase(int count);
    int stop_at;
    int r;
    stop_at = sent_total + count;
    while (sent_total < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) noise_query(pick_cell(lat_w), pick_cell(lat_h), pick_frac(), pick_frac());
      else if (r < 85) grad_write($urandom_range(lat_w), $urandom_range(lat_h));
      else grad_write($urandom_range(GRID_TOP), $urandom_range(GRID_TOP));
    end
  endtask

  // response side: random stalls, one long hold-off, steady stretches
  initial begin : rsp_side
    bit held;
    held = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_total >= HOLD_AT) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp.ready <= 1'b1;
      end else if (steady) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= STALL_PCT);
      end
    end
  end

  // watchdog on cycles without any accepted transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    rst         <= 1'b1;
    cfg.valid   <= 1'b0;
    cfg.index   <= REG_GRID_WIDTH;
    cfg.data    <= '0;
    req.valid   <= 1'b0;
    req.command <= CMD_WRITE;
    req.grid_x  <= '0;
    req.grid_y  <= '0;
    req.grad_x  <= '0;
    req.grad_y  <= '0;
    req.coord_x <= '0;
    req.coord_y <= '0;
    lat_w = MAX_GRID_DEFAULT;
    lat_h = MAX_GRID_DEFAULT;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset lattice size: gradient saturation, fraction edges, far corner
    send_req(CMD_WRITE, 0, 0, 16'sh4000, 16'shC000, '0, '0);
    send_req(CMD_WRITE, 1, 0, 16'sh8000, 16'sh7FFF, '1, '1);
    send_req(CMD_WRITE, 0, 1, 16'sh3FFF, 16'sh0000, '0, '1);
    send_req(CMD_WRITE, 1, 1, 16'shC000, 16'sh3FFF, '1, '0);
    noise_query(0, 0, '0, '0);
    noise_query(0, 0, FRAC_TOP[FRAC-1:0], FRAC_TOP[FRAC-1:0]);
    noise_query(0, 0, FRAC'(512), FRAC'(1));
    noise_query(GRID_TOP, GRID_TOP, FRAC_TOP[FRAC-1:0], FRAC_TOP[FRAC-1:0]);
    noise_query(GRID_TOP - 1, GRID_TOP - 1, FRAC'(300), FRAC'(700));

    // small lattice: writes outside it, corners outside it
    wait_drained();
    set_lattice(3, 2);
    grad_write(4, 0);
    grad_write(0, 3);
    grad_write(GRID_TOP, GRID_TOP);
    grad_write(3, 2);
    noise_query(3, 2, FRAC'(700), FRAC'(300));
    noise_query(10, 10, pick_frac(), pick_frac());
    noise_query(2, 1, pick_frac(), pick_frac());

    // random mixes over several lattice sizes
    wait_drained();
    set_lattice(GRID_TOP, GRID_TOP);
    mix_phase(400);
    wait_drained();
    set_lattice(0, 0);
    mix_phase(150);
    wait_drained();
    set_lattice(GRID_TOP, 0);
    mix_phase(200);
    wait_drained();
    set_lattice(0, GRID_TOP);
    mix_phase(200);
    wait_drained();
    set_lattice(7, 5);
    steady = 1'b1;
    mix_phase(300);
    steady = 1'b0;
    wait_drained();
    set_lattice($urandom_range(GRID_TOP), $urandom_range(GRID_TOP));
    mix_phase(300);
    wait_drained();
    set_lattice(GRID_TOP, GRID_TOP);
    mix_phase(300);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
